// ----- rtl/core/pvc_pkg.sv -----
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types and constants of the point vortex convection step unit.
// ----------------------------------------------------------------------------
package pvc_pkg;

	localparam int VORTEX_MAX = 64;
	localparam int WRAP_LIMIT = 4;

	localparam int IDX_W = $clog2(VORTEX_MAX);
	localparam int CNT_W = $clog2(VORTEX_MAX + 1);
	localparam int WRAP_W = $clog2(WRAP_LIMIT + 1);

	localparam int POS_W = 24;
	localparam int VEL_W = 32;
	localparam int DOM_W = 23;
	localparam int DT_W = 16;
	localparam int THR_W = 48;
	localparam int CFG_W = 48;
	localparam int REG_W = 2;

	localparam int MAG_W = 24;               // |g|, |dx|, |dy|
	localparam int PROD_W = 2 * MAG_W;       // |g|*|delta|
	localparam int D_W = 2 * MAG_W + 1;      // squared distance
	localparam int NUM_W = 63;               // |g|*|delta| << 16
	localparam int QHI_W = NUM_W - 32;
	localparam int K_W = 30;
	localparam logic [K_W-1:0] INV_TWO_PI = 30'd683565276;

	typedef enum logic [REG_W-1:0] {
		REG_DOMAIN = 2'd0,
		REG_STEP   = 2'd1,
		REG_THRESH = 2'd2
	} pvc_reg_t;

	typedef struct packed {
		logic                    valid;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] g;
	} pvc_vortex_t;

	typedef struct packed {
		logic start;
		logic neg_x;
		logic neg_y;
	} pvc_pair_req_t;

endpackage

// ----- rtl/core/pvc_cell.sv -----
// ----------------------------------------------------------------------------
// pvc_cell
// One vortex slot of the storage ring; takes its neighbour's word on shift.
// ----------------------------------------------------------------------------
module pvc_cell import pvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift,
	input  logic        clear,
	input  pvc_vortex_t d_in,
	output pvc_vortex_t q
);

	logic                    valid_q;
	logic signed [POS_W-1:0] x_q;
	logic signed [POS_W-1:0] y_q;
	logic signed [POS_W-1:0] g_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			x_q <= d_in.x;
			y_q <= d_in.y;
			g_q <= d_in.g;
		end
	end

	assign q = '{valid: valid_q, x: x_q, y: y_q, g: g_q};

endmodule

// ----- rtl/core/pvc_pair.sv -----
// ----------------------------------------------------------------------------
// pvc_pair
// Biot-Savart pair term: two radix-2 dividers sharing the squared distance,
// then scaling by 1/(2*pi), sign and clamp to 32 bits.
// ----------------------------------------------------------------------------
module pvc_pair import pvc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pvc_pair_req_t           req,
	input  logic [D_W-1:0]          d,
	input  logic [NUM_W-1:0]        num_x,
	input  logic [NUM_W-1:0]        num_y,
	output logic                    done,
	output logic signed [VEL_W-1:0] term_x,
	output logic signed [VEL_W-1:0] term_y
);

	typedef enum logic [1:0] {P_IDLE, P_DIV, P_SCALE, P_OUT} pstate_t;

	localparam int IT_W = $clog2(NUM_W);

	pstate_t             state_q;
	logic [IT_W-1:0]     it_q;
	logic [D_W-1:0]      d_q;
	logic [NUM_W-1:0]    qx_q, qy_q;
	logic [D_W-1:0]      rx_q, ry_q;
	logic                negx_q, negy_q;
	logic [QHI_W+K_W-1:0] phx_q, phy_q;
	logic [32+K_W-1:0]    plx_q, ply_q;
	logic                done_q;
	logic signed [VEL_W-1:0] tx_q, ty_q;

	logic [D_W:0] remx, remy;
	logic [32+K_W-1:0] rsx, rsy;

	function automatic logic signed [VEL_W-1:0] finish(input logic [32+K_W-1:0] r,
			input logic neg);
		logic [VEL_W-1:0] tmag;
		begin
			tmag = (|r[32+K_W-1:VEL_W-1]) ? {1'b1, {(VEL_W-1){1'b0}}} : r[VEL_W-1:0];
			if (neg)
				finish = -$signed(tmag);
			else if (tmag[VEL_W-1])
				finish = {1'b0, {(VEL_W-1){1'b1}}};
			else
				finish = $signed(tmag);
		end
	endfunction

	assign remx = {rx_q, qx_q[NUM_W-1]};
	assign remy = {ry_q, qy_q[NUM_W-1]};
	assign rsx = (32+K_W)'(phx_q) + (32+K_W)'(plx_q[32+K_W-1:32]);
	assign rsy = (32+K_W)'(phy_q) + (32+K_W)'(ply_q[32+K_W-1:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				P_IDLE: if (req.start) state_q <= P_DIV;
				P_DIV: if (it_q == IT_W'(NUM_W - 1)) state_q <= P_SCALE;
				P_SCALE: state_q <= P_OUT;
				P_OUT: begin
					done_q  <= 1'b1;
					state_q <= P_IDLE;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			P_IDLE: begin
				d_q    <= d;
				qx_q   <= num_x;
				qy_q   <= num_y;
				rx_q   <= '0;
				ry_q   <= '0;
				it_q   <= '0;
				negx_q <= req.neg_x;
				negy_q <= req.neg_y;
			end
			P_DIV: begin
				it_q <= it_q + 1'b1;
				if (remx >= {1'b0, d_q}) begin
					rx_q <= D_W'(remx - {1'b0, d_q});
					qx_q <= {qx_q[NUM_W-2:0], 1'b1};
				end else begin
					rx_q <= remx[D_W-1:0];
					qx_q <= {qx_q[NUM_W-2:0], 1'b0};
				end
				if (remy >= {1'b0, d_q}) begin
					ry_q <= D_W'(remy - {1'b0, d_q});
					qy_q <= {qy_q[NUM_W-2:0], 1'b1};
				end else begin
					ry_q <= remy[D_W-1:0];
					qy_q <= {qy_q[NUM_W-2:0], 1'b0};
				end
			end
			P_SCALE: begin
				phx_q <= qx_q[NUM_W-1:32] * INV_TWO_PI;
				plx_q <= qx_q[31:0] * INV_TWO_PI;
				phy_q <= qy_q[NUM_W-1:32] * INV_TWO_PI;
				ply_q <= qy_q[31:0] * INV_TWO_PI;
			end
			P_OUT: begin
				tx_q <= finish(rsx, negx_q);
				ty_q <= finish(rsy, negy_q);
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign term_x = tx_q;
	assign term_y = ty_q;

endmodule

// ----- rtl/core/point_vortex_convection_step_unit.sv -----
// ----------------------------------------------------------------------------
// point_vortex_convection_step_unit
// One Euler convection step of up to VORTEX_MAX point vortices in a periodic
// square, with a ring of vortex cells feeding a shared pair-term unit.
//
// Input words (pos_x, pos_y, strength, final_vortex) are loaded one per cycle
// on in_valid/in_ready; words beyond VORTEX_MAX are dropped. A word with
// final_vortex set starts the step and in_ready stays low until the last
// result word has been handed to the output register.
// For each vortex the ring rotates once through all VORTEX_MAX slots; every
// other stored vortex adds operand set-up, a 63-bit division, scaling and
// accumulation (only the set-up if the pair is skipped). Then come the
// displacement, the wrapping and the output of the result word.
// Results leave in load order on out_valid/out_ready; a stalled receiver
// holds the current word and stops the computation at the next result.
// Reset clears the store and the output register and sets the registers to
// their defaults. wr_en writes wr_data to register wr_index.
// ----------------------------------------------------------------------------
module point_vortex_convection_step_unit import pvc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [REG_W-1:0]        wr_index,
	input  logic [CFG_W-1:0]        wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] strength,
	input  logic                    final_vortex,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [IDX_W-1:0]        vortex_index,
	output logic signed [POS_W-1:0] new_x,
	output logic signed [POS_W-1:0] new_y,
	output logic signed [VEL_W-1:0] vel_x,
	output logic signed [VEL_W-1:0] vel_y,
	output logic                    wrap_fault,
	output logic                    end_of_set
);

	typedef enum logic [3:0] {
		ST_LOAD, ST_VISIT, ST_DIFF, ST_SQ, ST_CHK, ST_DIV, ST_ACC,
		ST_MUL, ST_ADD, ST_WRAP, ST_EMIT
	} state_t;

	localparam int P_W = VEL_W + 2;
	localparam int PR_W = VEL_W + DT_W + 1;

	state_t state_q;

	logic [DOM_W-1:0] dom_q;
	logic [DT_W-1:0]  dt_q;
	logic [THR_W-1:0] thr_q;

	pvc_vortex_t ring [VORTEX_MAX];
	pvc_vortex_t tail_in;
	logic        shift, clear_set, load_word;

	logic [CNT_W-1:0] cnt_q, vis_q;
	logic [IDX_W-1:0] m_q, s_q;
	logic             last_q;

	logic signed [POS_W-1:0] tx_q, ty_q, nx_q, ny_q, hx_q, hy_q, hg_q;
	logic [MAG_W-1:0]        adx_q, ady_q, ag_q;
	logic                    dxpos_q, dyneg_q, gneg_q;
	logic [D_W-1:0]          d_q;
	logic [PROD_W-1:0]       numx_q, numy_q;
	logic                    negx_q, negy_q;
	logic signed [VEL_W-1:0] ux_q, uy_q;
	logic signed [PR_W-1:0]  prx_q, pry_q;
	logic signed [P_W-1:0]   px_q, py_q;
	logic [WRAP_W-1:0]       k_q;

	pvc_pair_req_t           req;
	logic                    pdone;
	logic signed [VEL_W-1:0] term_x, term_y;

	logic signed [POS_W:0] dx, dy;
	logic                  skip, out_free, fx, fy;

	function automatic logic signed [VEL_W-1:0] sat_add(input logic signed [VEL_W-1:0] a,
			input logic signed [VEL_W-1:0] b);
		logic signed [VEL_W:0] s;
		begin
			s = {a[VEL_W-1], a} + {b[VEL_W-1], b};
			if (s[VEL_W] != s[VEL_W-1])
				sat_add = s[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
			else
				sat_add = s[VEL_W-1:0];
		end
	endfunction

	function automatic logic above(input logic signed [P_W-1:0] p, input logic [DOM_W-1:0] dm);
		logic signed [P_W:0] p2, dd;
		begin
			p2 = {p, 1'b0};
			dd = $signed((P_W+1)'(dm));
			above = p2 > dd;
		end
	endfunction

	function automatic logic below(input logic signed [P_W-1:0] p, input logic [DOM_W-1:0] dm);
		logic signed [P_W:0] p2, dd;
		begin
			p2 = {p, 1'b0};
			dd = $signed((P_W+1)'(dm));
			below = p2 < -dd;
		end
	endfunction

	function automatic logic signed [P_W-1:0] wrap1(input logic signed [P_W-1:0] p,
			input logic [DOM_W-1:0] dm);
		logic signed [P_W-1:0] dd;
		begin
			dd = $signed(P_W'(dm));
			if (above(p, dm))
				wrap1 = p - dd;
			else if (below(p, dm))
				wrap1 = p + dd;
			else
				wrap1 = p;
		end
	endfunction

	function automatic logic signed [POS_W-1:0] clamp24(input logic signed [P_W-1:0] p);
		begin
			if (p > $signed(P_W'({1'b0, {(POS_W-1){1'b1}}})))
				clamp24 = {1'b0, {(POS_W-1){1'b1}}};
			else if (p < -$signed(P_W'({1'b1, {(POS_W-1){1'b0}}})))
				clamp24 = {1'b1, {(POS_W-1){1'b0}}};
			else
				clamp24 = p[POS_W-1:0];
		end
	endfunction

	// storage ring: head is cell 0, words enter at the tail
	assign load_word = in_valid && in_ready && (cnt_q < CNT_W'(VORTEX_MAX));
	assign shift     = load_word || (state_q == ST_VISIT);
	assign tail_in   = (state_q == ST_LOAD) ?
		'{valid: 1'b1, x: pos_x, y: pos_y, g: strength} : ring[0];
	assign out_free  = !out_valid || out_ready;
	assign clear_set = (state_q == ST_EMIT) && out_free && ({1'b0, m_q} == cnt_q - 1'b1);

	genvar gi;
	generate
		for (gi = 0; gi < VORTEX_MAX; gi++) begin : g_cell
			pvc_vortex_t d_in;
			if (gi == VORTEX_MAX - 1) begin : g_tail
				assign d_in = tail_in;
			end else begin : g_mid
				assign d_in = ring[gi+1];
			end
			pvc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.clear  (clear_set),
				.d_in   (d_in),
				.q      (ring[gi])
			);
		end
	endgenerate

	pvc_pair u_pair (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.d      (d_q),
		.num_x  ({numx_q[NUM_W-17:0], 16'd0}),
		.num_y  ({numy_q[NUM_W-17:0], 16'd0}),
		.done   (pdone),
		.term_x (term_x),
		.term_y (term_y)
	);

	assign skip = (d_q == '0) || (d_q < D_W'(thr_q));
	assign req  = '{start: (state_q == ST_CHK) && !skip, neg_x: negx_q, neg_y: negy_q};

	assign dx = {tx_q[POS_W-1], tx_q} - {hx_q[POS_W-1], hx_q};
	assign dy = {ty_q[POS_W-1], ty_q} - {hy_q[POS_W-1], hy_q};
	assign fx = above(px_q, dom_q) || below(px_q, dom_q);
	assign fy = above(py_q, dom_q) || below(py_q, dom_q);

	assign in_ready = (state_q == ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dom_q <= DOM_W'(1048576);
			dt_q  <= DT_W'(655);
			thr_q <= THR_W'(16);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DOMAIN: dom_q <= wr_data[DOM_W-1:0];
				REG_STEP:   dt_q  <= wr_data[DT_W-1:0];
				REG_THRESH: thr_q <= wr_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			vis_q     <= '0;
			m_q       <= '0;
			s_q       <= '0;
			last_q    <= 1'b0;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != ST_EMIT)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (load_word)
						cnt_q <= cnt_q + 1'b1;
					if (in_valid && final_vortex) begin
						state_q <= ST_VISIT;
						m_q     <= '0;
						s_q     <= '0;
						vis_q   <= '0;
						ux_q    <= '0;
						uy_q    <= '0;
					end
				end
				ST_VISIT: begin
					s_q    <= (s_q == IDX_W'(VORTEX_MAX - 1)) ? '0 : s_q + 1'b1;
					last_q <= (s_q == IDX_W'(VORTEX_MAX - 1));
					hx_q   <= ring[0].x;
					hy_q   <= ring[0].y;
					hg_q   <= ring[0].g;
					if (ring[0].valid) begin
						vis_q <= vis_q + 1'b1;
						if (m_q == '0 && vis_q == '0) begin
							tx_q <= ring[0].x;
							ty_q <= ring[0].y;
						end
						if (vis_q == CNT_W'(m_q) + 1'b1) begin
							nx_q <= ring[0].x;
							ny_q <= ring[0].y;
						end
					end
					if (ring[0].valid && vis_q != CNT_W'(m_q))
						state_q <= ST_DIFF;
					else if (s_q == IDX_W'(VORTEX_MAX - 1))
						state_q <= ST_MUL;
				end
				ST_DIFF: begin
					adx_q   <= dx[POS_W] ? MAG_W'(-dx) : MAG_W'(dx);
					ady_q   <= dy[POS_W] ? MAG_W'(-dy) : MAG_W'(dy);
					dxpos_q <= !dx[POS_W] && (dx != '0);
					dyneg_q <= dy[POS_W];
					gneg_q  <= hg_q[POS_W-1];
					ag_q    <= hg_q[POS_W-1] ? MAG_W'(-hg_q) : MAG_W'(hg_q);
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					d_q     <= D_W'(adx_q * adx_q) + D_W'(ady_q * ady_q);
					numx_q  <= ag_q * ady_q;
					numy_q  <= ag_q * adx_q;
					negx_q  <= gneg_q ^ dyneg_q;
					negy_q  <= gneg_q ^ dxpos_q;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (!skip)
						state_q <= ST_DIV;
					else
						state_q <= last_q ? ST_MUL : ST_VISIT;
				end
				ST_DIV: if (pdone) state_q <= ST_ACC;
				ST_ACC: begin
					ux_q    <= sat_add(ux_q, term_x);
					uy_q    <= sat_add(uy_q, term_y);
					state_q <= last_q ? ST_MUL : ST_VISIT;
				end
				ST_MUL: begin
					prx_q   <= PR_W'(ux_q * $signed({1'b0, dt_q}));
					pry_q   <= PR_W'(uy_q * $signed({1'b0, dt_q}));
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					px_q    <= P_W'(tx_q) + P_W'($signed(prx_q[PR_W-1:DT_W]));
					py_q    <= P_W'(ty_q) + P_W'($signed(pry_q[PR_W-1:DT_W]));
					k_q     <= '0;
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					px_q <= wrap1(px_q, dom_q);
					py_q <= wrap1(py_q, dom_q);
					k_q  <= k_q + 1'b1;
					if (k_q == WRAP_W'(WRAP_LIMIT - 1))
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						vortex_index <= m_q;
						new_x        <= clamp24(px_q);
						new_y        <= clamp24(py_q);
						vel_x        <= ux_q;
						vel_y        <= uy_q;
						wrap_fault   <= fx || fy;
						end_of_set   <= clear_set;
						ux_q         <= '0;
						uy_q         <= '0;
						vis_q        <= '0;
						s_q          <= '0;
						if (clear_set) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							m_q     <= m_q + 1'b1;
							tx_q    <= nx_q;
							ty_q    <= ny_q;
							state_q <= ST_VISIT;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule
